/* src/pf_pkg.sv */
// Package for the prime factorizer: microcode types, step addresses and control ROM.
package pf_pkg;

  localparam int unsigned PcWidth = 4;

  typedef logic [PcWidth-1:0] pc_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_START,
    OP_INC_D,
    OP_EMIT_D,
    OP_EMIT_REM,
    OP_EMIT_NONE
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_NO_INPUT,
    C_REM_LE1,
    C_DIV_BUSY,
    C_D_GT_Q,
    C_R_ZERO,
    C_OUT_FULL
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   tgt_true;
    pc_t   tgt_false;
  } ucode_word_t;

  typedef struct packed {
    logic in_valid;
    logic rem_le1;
    logic div_busy;
    logic d_gt_q;
    logic r_zero;
    logic out_full;
  } status_t;

  typedef struct packed {
    op_e op;
  } ctrl_t;

  localparam pc_t StIdle     = pc_t'(0);
  localparam pc_t StCheck    = pc_t'(1);
  localparam pc_t StDivStart = pc_t'(2);
  localparam pc_t StDivWait  = pc_t'(3);
  localparam pc_t StLoopTest = pc_t'(4);
  localparam pc_t StModTest  = pc_t'(5);
  localparam pc_t StEmitD    = pc_t'(6);
  localparam pc_t StTailTest = pc_t'(7);
  localparam pc_t StEmitRem  = pc_t'(8);
  localparam pc_t StEmitNone = pc_t'(9);

  // Op fires only on the false branch of the word's condition.
  function automatic ucode_word_t ucode_rom(input pc_t pc);
    ucode_word_t w;
    case (pc)
      StIdle:     w = '{OP_LOAD,      C_NO_INPUT, StIdle,     StCheck};
      StCheck:    w = '{OP_NOP,       C_REM_LE1,  StEmitNone, StDivStart};
      StDivStart: w = '{OP_DIV_START, C_NEVER,    StIdle,     StDivWait};
      StDivWait:  w = '{OP_NOP,       C_DIV_BUSY, StDivWait,  StLoopTest};
      StLoopTest: w = '{OP_NOP,       C_D_GT_Q,   StTailTest, StModTest};
      StModTest:  w = '{OP_INC_D,     C_R_ZERO,   StEmitD,    StDivStart};
      StEmitD:    w = '{OP_EMIT_D,    C_OUT_FULL, StEmitD,    StDivStart};
      StTailTest: w = '{OP_NOP,       C_REM_LE1,  StIdle,     StEmitRem};
      StEmitRem:  w = '{OP_EMIT_REM,  C_OUT_FULL, StEmitRem,  StIdle};
      StEmitNone: w = '{OP_EMIT_NONE, C_OUT_FULL, StEmitNone, StIdle};
      default:    w = '{OP_NOP,       C_NEVER,    StIdle,     StIdle};
    endcase
    return w;
  endfunction

endpackage

/* src/pf_divider.sv */
// Restoring divider: one quotient bit per cycle.
module pf_divider #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned DIV_WIDTH   = 17
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [DIV_WIDTH-1:0]   divisor_i,
  output logic                   busy_o,
  output logic [VALUE_WIDTH-1:0] quotient_o,
  output logic [DIV_WIDTH-1:0]   remainder_o
);

  localparam int unsigned CntWidth = $clog2(VALUE_WIDTH);

  logic                   busy_q, busy_d;
  logic [CntWidth-1:0]    cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] quo_q, quo_d;
  logic [DIV_WIDTH-1:0]   rem_q, rem_d;
  logic [DIV_WIDTH:0]     trial;
  logic [DIV_WIDTH:0]     diff;
  logic                   fits;

  assign trial = {rem_q, quo_q[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign fits  = trial >= {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quo_d = {quo_q[VALUE_WIDTH-2:0], fits};
      rem_d = fits ? diff[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
      cnt_d = cnt_q + CntWidth'(1);
      if (cnt_q == CntWidth'(VALUE_WIDTH - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign busy_o      = busy_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

/* src/pf_sequencer.sv */
// Microcode sequencer: step counter, control ROM and branch condition select.
module pf_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pf_pkg::status_t status_i,
  output pf_pkg::ctrl_t   ctrl_o
);

  pf_pkg::pc_t         pc_q, pc_d;
  pf_pkg::ucode_word_t word;
  logic                taken;

  assign word = pf_pkg::ucode_rom(pc_q);

  always_comb begin
    case (word.cond)
      pf_pkg::C_NEVER:    taken = 1'b0;
      pf_pkg::C_NO_INPUT: taken = !status_i.in_valid;
      pf_pkg::C_REM_LE1:  taken = status_i.rem_le1;
      pf_pkg::C_DIV_BUSY: taken = status_i.div_busy;
      pf_pkg::C_D_GT_Q:   taken = status_i.d_gt_q;
      pf_pkg::C_R_ZERO:   taken = status_i.r_zero;
      pf_pkg::C_OUT_FULL: taken = status_i.out_full;
      default:            taken = 1'b0;
    endcase
  end

  assign pc_d      = taken ? word.tgt_true : word.tgt_false;
  assign ctrl_o.op = taken ? pf_pkg::OP_NOP : word.op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= pf_pkg::StIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

/* src/prime_factorizer.sv */
// Trial-division factorizer: datapath, output register, divider and sequencer.
// Each trial divisor costs one serial division; a 32-bit prime takes up to ~65536 trials.
// One item at a time; input is taken again once the last factor sits in the output register.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and clears the output valid.
module prime_factorizer #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]  s_axis_tdata_i,  // [VALUE_WIDTH-1:0] value
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [((VALUE_WIDTH+7)/8)*8-1:0]  m_axis_tdata_o,  // [VALUE_WIDTH-1:0] factor
  output logic                              m_axis_tlast_o,
  output logic                              m_axis_tuser_o   // none
);

  localparam int unsigned DivWidth  = (VALUE_WIDTH + 1) / 2 + 1;
  localparam int unsigned DataWidth = ((VALUE_WIDTH + 7) / 8) * 8;

  pf_pkg::status_t        status;
  pf_pkg::ctrl_t          ctrl;

  logic [VALUE_WIDTH-1:0] rem_q, rem_d;
  logic [DivWidth-1:0]    d_q, d_d;
  logic                   out_valid_q, out_valid_d;
  logic [VALUE_WIDTH-1:0] factor_q, factor_d;
  logic                   last_q, last_d;
  logic                   none_q, none_d;

  logic                   div_busy;
  logic [VALUE_WIDTH-1:0] quotient;
  logic [DivWidth-1:0]    remainder;
  logic                   out_full;

  assign out_full = out_valid_q && !m_axis_tready_i;

  assign status.in_valid = s_axis_tvalid_i;
  assign status.rem_le1  = rem_q <= VALUE_WIDTH'(1);
  assign status.div_busy = div_busy;
  assign status.d_gt_q   = VALUE_WIDTH'(d_q) > quotient;
  assign status.r_zero   = remainder == '0;
  assign status.out_full = out_full;

  pf_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .status_i(status),
    .ctrl_o  (ctrl)
  );

  pf_divider #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .DIV_WIDTH  (DivWidth)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl.op == pf_pkg::OP_DIV_START),
    .dividend_i (rem_q),
    .divisor_i  (d_q),
    .busy_o     (div_busy),
    .quotient_o (quotient),
    .remainder_o(remainder)
  );

  assign s_axis_tready_o = ctrl.op == pf_pkg::OP_LOAD;

  always_comb begin
    rem_d       = rem_q;
    d_d         = d_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    factor_d    = factor_q;
    last_d      = last_q;
    none_d      = none_q;
    case (ctrl.op)
      pf_pkg::OP_LOAD: begin
        rem_d = s_axis_tdata_i[VALUE_WIDTH-1:0];
        d_d   = DivWidth'(2);
      end
      pf_pkg::OP_INC_D: begin
        d_d = d_q + DivWidth'(1);
      end
      pf_pkg::OP_EMIT_D: begin
        rem_d       = quotient;
        out_valid_d = 1'b1;
        factor_d    = VALUE_WIDTH'(d_q);
        last_d      = quotient == VALUE_WIDTH'(1);
        none_d      = 1'b0;
      end
      pf_pkg::OP_EMIT_REM: begin
        out_valid_d = 1'b1;
        factor_d    = rem_q;
        last_d      = 1'b1;
        none_d      = 1'b0;
      end
      pf_pkg::OP_EMIT_NONE: begin
        out_valid_d = 1'b1;
        factor_d    = '0;
        last_d      = 1'b1;
        none_d      = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    d_q      <= d_d;
    factor_q <= factor_d;
    last_q   <= last_d;
    none_q   <= none_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = DataWidth'(factor_q);
  assign m_axis_tlast_o  = last_q;
  assign m_axis_tuser_o  = none_q;

endmodule
